// ===== hw/rtl/mbp_pkg.sv =====
// Shared types and constants for the MSB-first bit packer with byte stuffing.
`default_nettype none

package mbp_pkg;

  localparam logic       FUNC_WRITE   = 1'b0;
  localparam logic       FUNC_FLUSH   = 1'b1;
  localparam logic [4:0] MAX_CODE_LEN = 5'd16;
  localparam logic [7:0] MARKER_BYTE  = 8'hFF;
  localparam logic [7:0] STUFF_BYTE   = 8'h00;
  localparam logic [4:0] BYTE_BITS    = 5'd8;

  typedef struct packed {
    logic        func;
    logic [15:0] code_bits;
    logic [4:0]  code_len;
  } code_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } pack_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_STUFF
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // take a new code item into the accumulator
    logic emit_top;   // move the top accumulator byte to the output register
    logic emit_stuff; // put the stuffed zero byte into the output register
    logic last;       // last flag for the byte being loaded
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic has_byte;   // at least eight bits wait in the accumulator
    logic has_two;    // at least sixteen bits wait in the accumulator
    logic top_marker; // top accumulator byte equals the marker byte
    logic out_free;   // output register can take a byte this cycle
  } stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/msb_bit_packer_byte_stuffing.sv =====
// Top level of the MSB-first bit packer with 0xFF/0x00 byte stuffing.
//
//   Channel   Signals                               Carries
//   code      code_valid, code_stall, code_item     write or flush command
//   pack      pack_valid, pack_stall, pack_item     packed byte with last flag
//
// An item is taken in the idle state and then yields its bytes, at most one
// per cycle into the single-byte output register while it can take a byte.
// An item with no result bytes still goes through the emit state to idle.
// Reset clears the accumulator, the controller and the output valid.
// A stall on the pack side holds the controller; code_stall is high while
// an item's bytes are still being produced.
`default_nettype none

module msb_bit_packer_byte_stuffing (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                code_valid,
  output logic                     code_stall,
  input  wire mbp_pkg::code_item_t code_item,
  output logic                     pack_valid,
  input  wire logic                pack_stall,
  output mbp_pkg::pack_item_t      pack_item
);

  mbp_pkg::cmd_t  cmd;
  mbp_pkg::stat_t stat;

  mbp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .code_valid (code_valid),
    .code_stall (code_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  mbp_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .code_item  (code_item),
    .cmd        (cmd),
    .stat       (stat),
    .pack_valid (pack_valid),
    .pack_stall (pack_stall),
    .pack_item  (pack_item)
  );

  // A transferred marker byte is followed at once by the stuffed zero byte.
  a_stuff_follows: assert property (@(posedge clk) disable iff (rst)
    pack_valid && !pack_stall && pack_item.out_byte == mbp_pkg::MARKER_BYTE
    |=> pack_valid && pack_item.out_byte == mbp_pkg::STUFF_BYTE)
    else $error("stuffed zero byte missing after marker byte");

  // A marker byte never ends an item's output.
  a_marker_not_last: assert property (@(posedge clk) disable iff (rst)
    pack_valid && pack_item.out_byte == mbp_pkg::MARKER_BYTE |-> !pack_item.last)
    else $error("marker byte flagged as last");

  // After an accepted item the block is busy producing its bytes.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    code_valid && !code_stall |=> code_stall)
    else $error("new item taken while previous item still in progress");

endmodule

`default_nettype wire

// ===== hw/rtl/mbp_datapath.sv =====
// Datapath: bit accumulator, byte extraction and output register.
`default_nettype none

module mbp_datapath (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire mbp_pkg::code_item_t code_item,
  input  wire mbp_pkg::cmd_t      cmd,
  output mbp_pkg::stat_t          stat,
  output logic                    pack_valid,
  input  wire logic               pack_stall,
  output mbp_pkg::pack_item_t     pack_item
);

  // Valid bits sit at the top of acc; cnt counts them (at most 23).
  logic [23:0] acc;
  logic [23:0] acc_next;
  logic [4:0]  cnt;
  logic [4:0]  cnt_next;
  logic [4:0]  len_sat;
  logic [15:0] code_al;
  logic [7:0]  pad;

  always_comb begin
    len_sat  = (code_item.code_len > mbp_pkg::MAX_CODE_LEN) ? mbp_pkg::MAX_CODE_LEN
                                                             : code_item.code_len;
    // Left-align the used code bits; the unused upper bits drop off the top.
    code_al  = code_item.code_bits << (mbp_pkg::MAX_CODE_LEN - len_sat);
    pad      = 8'hFF >> cnt[2:0];
    acc_next = acc;
    cnt_next = cnt;
    priority if (cmd.load) begin
      if (code_item.func == mbp_pkg::FUNC_WRITE) begin
        acc_next = acc | ({code_al, 8'h00} >> cnt[2:0]);
        cnt_next = cnt + len_sat;
      end else if (cnt != 5'd0) begin
        acc_next = acc | {pad, 16'h0000};
        cnt_next = mbp_pkg::BYTE_BITS;
      end
    end else if (cmd.emit_top) begin
      acc_next = {acc[15:0], 8'h00};
      cnt_next = cnt - mbp_pkg::BYTE_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      cnt <= '0;
    end else begin
      acc <= acc_next;
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pack_valid <= 1'b0;
    end else if (cmd.emit_top || cmd.emit_stuff) begin
      pack_valid <= 1'b1;
    end else if (!pack_stall) begin
      pack_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_top) begin
      pack_item.out_byte <= acc[23:16];
      pack_item.last     <= cmd.last;
    end else if (cmd.emit_stuff) begin
      pack_item.out_byte <= mbp_pkg::STUFF_BYTE;
      pack_item.last     <= cmd.last;
    end
  end

  always_comb begin
    stat.has_byte   = (cnt[4:3] != 2'b00);
    stat.has_two    = cnt[4];
    stat.top_marker = (acc[23:16] == mbp_pkg::MARKER_BYTE);
    stat.out_free   = !pack_valid || !pack_stall;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mbp_ctrl.sv =====
// Controller: sequences loading, byte emission and zero stuffing.
`default_nettype none

module mbp_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           code_valid,
  output logic                code_stall,
  input  wire mbp_pkg::stat_t stat,
  output mbp_pkg::cmd_t       cmd
);

  mbp_pkg::state_t state;
  mbp_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mbp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    code_stall = (state != mbp_pkg::ST_IDLE);
    unique case (state)
      mbp_pkg::ST_IDLE: begin
        if (code_valid) begin
          cmd.load   = 1'b1;
          state_next = mbp_pkg::ST_EMIT;
        end
      end
      mbp_pkg::ST_EMIT: begin
        if (!stat.has_byte) begin
          state_next = mbp_pkg::ST_IDLE;
        end else if (stat.out_free) begin
          cmd.emit_top = 1'b1;
          // Last only when no stuffed byte and no further full byte follow.
          cmd.last     = !stat.top_marker && !stat.has_two;
          if (stat.top_marker) begin
            state_next = mbp_pkg::ST_STUFF;
          end else if (!stat.has_two) begin
            state_next = mbp_pkg::ST_IDLE;
          end
        end
      end
      mbp_pkg::ST_STUFF: begin
        if (stat.out_free) begin
          cmd.emit_stuff = 1'b1;
          cmd.last       = !stat.has_byte;
          state_next     = stat.has_byte ? mbp_pkg::ST_EMIT : mbp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mbp_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire
